### sv/rect_overlap_table_assert.svh
// Assertion macros for the rectangle overlap table.
// Used by the top level only; no other dependencies.
`ifndef RECT_OVERLAP_TABLE_ASSERT_SVH
`define RECT_OVERLAP_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ROT_ASSERT_NOW(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("rect_overlap_table: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ROT_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("rect_overlap_table: assertion failed");

`endif

### sv/rot_pkg.sv
// Shared types and codes for the rectangle overlap table.
// No dependencies; used by every module of the block.
`default_nettype none

package rot_pkg;

    localparam int COORD_W = 12;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int CNT_OUT_W = 7;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } rect_t;

    typedef struct packed {
        logic [EDGE_W-1:0]  right;
        logic [EDGE_W-1:0]  bottom;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } qbox_t;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] stored_count;
        logic                 hit;
        logic                 add_ok;
    } result_t;

endpackage

`default_nettype wire

### sv/rect_overlap_table.sv
// Top level of the rectangle overlap table: control sequencer and output register.
// Depends on rot_pkg, rot_rect_mem, rot_overlap and rect_overlap_table_assert.svh.
//
//   Channel  Direction  Fields (lowest bit up)
//   s_       in         tdata: rect_x, rect_y, rect_w, rect_h; tuser: kind
//   m_       out        tdata: add_ok, hit, stored_count
//
// An add goes from idle straight to the done state. A query scans the stored
// rectangles through the single read port of the store, one entry a cycle, then
// drains the read register before the done state; an empty table skips the scan.
// Reset clears the count and the control state; the store itself is not cleared.
// A new word is taken while the previous result still waits in the output register;
// the sequencer holds its finished result until that register is free.
`default_nettype none

module rect_overlap_table #(
    parameter int MAX_RECTS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // rect_x, rect_y, rect_w, rect_h
    input  wire logic [0:0]  s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // add_ok, hit, stored_count
);

    `include "rect_overlap_table_assert.svh"

    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    idx_inc;
    rot_pkg::qbox_t   qbox_reg, qbox_next;
    logic             hit_reg, hit_next;
    logic             add_ok_reg, add_ok_next;
    logic             rd_vld_reg;
    logic             m_valid_reg, m_valid_next;
    rot_pkg::result_t m_data_reg, m_data_next;

    rot_pkg::rect_t   in_rect;
    rot_pkg::rect_t   rd_data;
    logic             mem_we;
    logic             cmp_hit;
    logic [CW+6:0]    count_ext;

    assign in_rect   = rot_pkg::rect_t'(s_tdata);
    assign s_tready  = (state_reg == ST_IDLE);
    assign idx_inc   = idx_reg + 1'b1;
    assign count_ext = {7'b0, count_reg};

    rot_rect_mem #(
        .DEPTH (MAX_RECTS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (in_rect),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    rot_overlap u_cmp (
        .qbox  (qbox_reg),
        .entry (rd_data),
        .hit   (cmp_hit)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        qbox_next    = qbox_reg;
        hit_next     = hit_reg;
        add_ok_next  = add_ok_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    qbox_next.x      = in_rect.x;
                    qbox_next.y      = in_rect.y;
                    qbox_next.right  = {1'b0, in_rect.x} + {1'b0, in_rect.w};
                    qbox_next.bottom = {1'b0, in_rect.y} + {1'b0, in_rect.h};
                    hit_next         = 1'b0;
                    add_ok_next      = 1'b0;
                    idx_next         = '0;
                    if (s_tuser[0] == rot_pkg::KIND_ADD) begin
                        if (count_reg != CW'(MAX_RECTS)) begin
                            mem_we      = 1'b1;
                            count_next  = count_reg + 1'b1;
                            add_ok_next = 1'b1;
                        end
                        state_next = ST_DONE;
                    end else if (count_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                idx_next = idx_inc;
                if (idx_inc == count_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.add_ok       = add_ok_reg;
                    m_data_next.hit          = hit_reg;
                    m_data_next.stored_count = count_ext[6:0];
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (rd_vld_reg && cmp_hit) begin
            hit_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_vld_reg  <= (state_reg == ST_SCAN);
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        qbox_reg   <= qbox_next;
        hit_reg    <= hit_next;
        add_ok_reg <= add_ok_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_data_reg};

    `ROT_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(MAX_RECTS))
    `ROT_ASSERT_NOW(a_read_in_scan, aclk, aresetn, rd_vld_reg,
                    state_reg == ST_SCAN || state_reg == ST_DRAIN)
    `ROT_ASSERT_NEXT(a_add_counts, aclk, aresetn,
                     s_tvalid && s_tready && s_tuser[0] == rot_pkg::KIND_ADD &&
                     count_reg != CW'(MAX_RECTS),
                     count_reg == $past(count_reg) + 1'b1)

endmodule

`default_nettype wire

### sv/rot_rect_mem.sv
// Rectangle store: one write port and one registered read port.
// Uses rot_pkg for the entry type.
`default_nettype none

module rot_rect_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic           aclk,
    input  wire logic           wr_en,
    input  wire logic [AW-1:0]  wr_addr,
    input  wire rot_pkg::rect_t wr_data,
    input  wire logic [AW-1:0]  rd_addr,
    output rot_pkg::rect_t      rd_data
);

    rot_pkg::rect_t mem [DEPTH];
    rot_pkg::rect_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### sv/rot_overlap.sv
// Strict overlap test of the held query box against one stored rectangle.
// Uses rot_pkg for the box and entry types.
`default_nettype none

module rot_overlap (
    input  wire rot_pkg::qbox_t qbox,
    input  wire rot_pkg::rect_t entry,
    output logic                hit
);

    logic [rot_pkg::EDGE_W-1:0] e_right;
    logic [rot_pkg::EDGE_W-1:0] e_bottom;

    assign e_right  = {1'b0, entry.x} + {1'b0, entry.w};
    assign e_bottom = {1'b0, entry.y} + {1'b0, entry.h};

    assign hit = (qbox.bottom > {1'b0, entry.y}) &&
                 ({1'b0, qbox.y} < e_bottom) &&
                 (qbox.right > {1'b0, entry.x}) &&
                 ({1'b0, qbox.x} < e_right);

endmodule

`default_nettype wire
